/* rtl/qbp_pkg.sv */
// Shared constants and register codes for the quadratic Bezier point evaluator.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package qbp_pkg;

	localparam int STEP_W = 11;
	localparam int DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int FRAC_W = 16;
	localparam int OUT_W = 32;
	localparam int TOL_W = 17;
	localparam logic [TOL_W-1:0] WHOLE_TOL_INV = 17'd100000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_A_X = 3'd0,
		REG_A_Y = 3'd1,
		REG_B_X = 3'd2,
		REG_B_Y = 3'd3,
		REG_C_X = 3'd4,
		REG_C_Y = 3'd5,
		REG_STEPS = 3'd6
	} cfg_reg_t;

endpackage
`default_nettype wire

/* rtl/quadratic_bezier_point.sv */
// Quadratic Bezier point evaluator, top level.
// Holds the configuration registers; depends on qbp_pkg, qbp_front, qbp_div_cell
// and qbp_round.
//
// Usage: write control points A, B, C (registers 0..5) and the step count N
// (register 6) on the cfg channel while the block is idle; cfg_ready is always
// high. Each item on the input channel carries a step index i, saturated to N,
// and yields exactly one item on the output channel: the index used, x and y of
// the curve at t = i/N in signed Q16.16, rounded half away from zero, and a flag
// set when the exact fractional part of |x| is at most 0.00001.
// The pipeline has five front stages, one divider cell for each of the
// COORD_BITS + 17 quotient bits, and the output register. One item is accepted
// per cycle while the pipeline is not stalled.
// Every stage holds its own valid bit, so a stalled receiver stops only the
// stages behind a full one; empty stages keep taking items until the chain
// fills. Reset empties the pipeline, clears the points and sets N to 1.
`default_nettype none
module quadratic_bezier_point import qbp_pkg::*; #(
	parameter int MAX_STEPS = 1024,
	parameter int COORD_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [STEP_W-1:0] step_index,
	output logic out_valid,
	input wire logic out_ready,
	output logic [STEP_W-1:0] index_echo,
	output logic signed [OUT_W-1:0] curve_x,
	output logic signed [OUT_W-1:0] curve_y,
	output logic x_is_whole
);
	localparam int CW = COORD_BITS;
	localparam int NWR = $clog2(MAX_STEPS + 1);
	localparam int NW = (NWR < STEP_W) ? NWR : STEP_W;
	localparam int DW = 2 * NW;
	localparam int FB = FRAC_W + 1;
	localparam int QB = CW + FB;
	localparam logic [31:0] MAX_N = 32'(MAX_STEPS);

	logic signed [CW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
	logic [STEP_W-1:0] steps_q;
	logic [CW+DATA_W-1:0] wr_ext;
	logic [NW-1:0] n_eff;

	assign cfg_ready = 1'b1;
	assign wr_ext = {CW'(0), cfg_data};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ax_q <= '0;
			ay_q <= '0;
			bx_q <= '0;
			by_q <= '0;
			cx_q <= '0;
			cy_q <= '0;
			steps_q <= STEP_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_A_X: ax_q <= wr_ext[CW-1:0];
				REG_A_Y: ay_q <= wr_ext[CW-1:0];
				REG_B_X: bx_q <= wr_ext[CW-1:0];
				REG_B_Y: by_q <= wr_ext[CW-1:0];
				REG_C_X: cx_q <= wr_ext[CW-1:0];
				REG_C_Y: cy_q <= wr_ext[CW-1:0];
				REG_STEPS: steps_q <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (steps_q == '0) begin
			n_eff = NW'(1);
		end else if (32'(steps_q) > MAX_N) begin
			n_eff = NW'(MAX_N);
		end else begin
			n_eff = NW'(steps_q);
		end
	end

	logic v_c [QB+1];
	logic rdy_c [QB+1];
	logic [STEP_W-1:0] idx_c [QB+1];
	logic [DW-1:0] den_c [QB+1];
	logic [1:0] neg_c [QB+1];
	logic [DW-1:0] rx_c [QB+1];
	logic [DW-1:0] ry_c [QB+1];
	logic [QB-1:0] lqx_c [QB+1];
	logic [QB-1:0] lqy_c [QB+1];
	logic [DW-1:0] rwh_c [QB+1];

	assign rwh_c[0] = '0;

	qbp_front #(.CW(CW), .NW(NW), .FB(FB)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .step_index(step_index),
		.n_eff(n_eff),
		.ax(ax_q), .ay(ay_q), .bx(bx_q), .by(by_q), .cx(cx_q), .cy(cy_q),
		.v_out(v_c[0]), .rdy_in(rdy_c[0]),
		.idx_out(idx_c[0]), .den_out(den_c[0]), .neg_out(neg_c[0]),
		.rem_x_out(rx_c[0]), .rem_y_out(ry_c[0]),
		.lq_x_out(lqx_c[0]), .lq_y_out(lqy_c[0])
	);

	// The remainder of the integer part is captured after the last integer cell.
	for (genvar k = 0; k < QB; k++) begin : g_cell
		qbp_div_cell #(.DW(DW), .QB(QB), .CAPTURE(k == CW - 1)) u_cell (
			.clk(clk), .arst_n(arst_n),
			.v_in(v_c[k]), .rdy_out(rdy_c[k]),
			.idx_in(idx_c[k]), .den_in(den_c[k]), .neg_in(neg_c[k]),
			.rem_x_in(rx_c[k]), .rem_y_in(ry_c[k]),
			.lq_x_in(lqx_c[k]), .lq_y_in(lqy_c[k]), .rwh_in(rwh_c[k]),
			.v_out(v_c[k+1]), .rdy_in(rdy_c[k+1]),
			.idx_out(idx_c[k+1]), .den_out(den_c[k+1]), .neg_out(neg_c[k+1]),
			.rem_x_out(rx_c[k+1]), .rem_y_out(ry_c[k+1]),
			.lq_x_out(lqx_c[k+1]), .lq_y_out(lqy_c[k+1]), .rwh_out(rwh_c[k+1])
		);
	end

	qbp_round #(.DW(DW), .QB(QB)) u_round (
		.clk(clk), .arst_n(arst_n),
		.v_in(v_c[QB]), .rdy_out(rdy_c[QB]),
		.idx_in(idx_c[QB]), .den_in(den_c[QB]), .neg_in(neg_c[QB]),
		.lq_x_in(lqx_c[QB]), .lq_y_in(lqy_c[QB]), .rwh_in(rwh_c[QB]),
		.out_valid(out_valid), .out_ready(out_ready),
		.index_echo(index_echo), .curve_x(curve_x), .curve_y(curve_y),
		.x_is_whole(x_is_whole)
	);

	// Only the quotient reaches the output; the final remainders are not needed.
	logic unused_rem;
	assign unused_rem = ^{rx_c[QB], ry_c[QB]};

endmodule
`default_nettype wire

/* rtl/qbp_front.sv */
// Front pipeline: index saturation, Bernstein weights, weighted sums and magnitude.
// Depends on qbp_pkg; feeds the first divider cell.
`default_nettype none
module qbp_front import qbp_pkg::*; #(
	parameter int CW = 16,
	parameter int NW = 11,
	parameter int FB = 17
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [STEP_W-1:0] step_index,
	input wire logic [NW-1:0] n_eff,
	input wire logic signed [CW-1:0] ax,
	input wire logic signed [CW-1:0] ay,
	input wire logic signed [CW-1:0] bx,
	input wire logic signed [CW-1:0] by,
	input wire logic signed [CW-1:0] cx,
	input wire logic signed [CW-1:0] cy,
	output logic v_out,
	input wire logic rdy_in,
	output logic [STEP_W-1:0] idx_out,
	output logic [2*NW-1:0] den_out,
	output logic [1:0] neg_out,
	output logic [2*NW-1:0] rem_x_out,
	output logic [2*NW-1:0] rem_y_out,
	output logic [CW+FB-1:0] lq_x_out,
	output logic [CW+FB-1:0] lq_y_out
);
	localparam int DW = 2 * NW;
	localparam int MW = DW + CW;
	localparam int SW = DW + CW + 1;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en1, en2, en3, en4, en5;

	logic [NW-1:0] n_s1, i_s1;
	logic [NW-1:0] i_s2;
	logic [DW-1:0] w0_s2, w1_s2, w2_s2, den_s2, den_s3, den_s4;
	logic [NW-1:0] i_s3, i_s4, i_s5;
	logic signed [SW-1:0] p0x_s3, p1x_s3, p2x_s3, p0y_s3, p1y_s3, p2y_s3;
	logic signed [SW-1:0] sx_s4, sy_s4;
	logic [MW-1:0] mx_s5, my_s5;
	logic [DW-1:0] den_s5;
	logic [1:0] neg_s5;

	logic [NW-1:0] i_sat, d_s1;
	logic [DW-1:0] di;
	logic signed [DW:0] w0s, w1s, w2s;
	logic signed [SW-1:0] nsx, nsy;

	assign en5 = !v_s5 || rdy_in;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_ready = en1;

	assign i_sat = (step_index > STEP_W'(n_eff)) ? n_eff : NW'(step_index);
	assign d_s1 = n_s1 - i_s1;
	assign di = DW'(d_s1) * DW'(i_s1);
	assign w0s = $signed({1'b0, w0_s2});
	assign w1s = $signed({1'b0, w1_s2});
	assign w2s = $signed({1'b0, w2_s2});
	assign nsx = -sx_s4;
	assign nsy = -sy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			n_s1 <= n_eff;
			i_s1 <= i_sat;
		end
		if (en2 && v_s1) begin
			i_s2 <= i_s1;
			w0_s2 <= DW'(d_s1) * DW'(d_s1);
			w1_s2 <= {di[DW-2:0], 1'b0};
			w2_s2 <= DW'(i_s1) * DW'(i_s1);
			den_s2 <= DW'(n_s1) * DW'(n_s1);
		end
		if (en3 && v_s2) begin
			i_s3 <= i_s2;
			den_s3 <= den_s2;
			p0x_s3 <= w0s * ax;
			p1x_s3 <= w1s * bx;
			p2x_s3 <= w2s * cx;
			p0y_s3 <= w0s * ay;
			p1y_s3 <= w1s * by;
			p2y_s3 <= w2s * cy;
		end
		if (en4 && v_s3) begin
			i_s4 <= i_s3;
			den_s4 <= den_s3;
			sx_s4 <= p0x_s3 + p1x_s3 + p2x_s3;
			sy_s4 <= p0y_s3 + p1y_s3 + p2y_s3;
		end
		if (en5 && v_s4) begin
			i_s5 <= i_s4;
			den_s5 <= den_s4;
			neg_s5 <= {sy_s4[SW-1], sx_s4[SW-1]};
			mx_s5 <= sx_s4[SW-1] ? nsx[MW-1:0] : sx_s4[MW-1:0];
			my_s5 <= sy_s4[SW-1] ? nsy[MW-1:0] : sy_s4[MW-1:0];
		end
	end

	// The dividend is the magnitude shifted left by FB fraction bits; its top part
	// is below the divisor, so it seeds the partial remainder directly.
	assign v_out = v_s5;
	assign idx_out = STEP_W'(i_s5);
	assign den_out = den_s5;
	assign neg_out = neg_s5;
	assign rem_x_out = mx_s5[MW-1:CW];
	assign rem_y_out = my_s5[MW-1:CW];
	assign lq_x_out = {mx_s5[CW-1:0], FB'(0)};
	assign lq_y_out = {my_s5[CW-1:0], FB'(0)};

endmodule
`default_nettype wire

/* rtl/qbp_div_cell.sv */
// One restoring-division cell: one quotient bit for each of the x and y lanes.
// Depends on qbp_pkg; cells are chained between qbp_front and qbp_round.
`default_nettype none
module qbp_div_cell import qbp_pkg::*; #(
	parameter int DW = 22,
	parameter int QB = 33,
	parameter bit CAPTURE = 1'b0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic v_in,
	output logic rdy_out,
	input wire logic [STEP_W-1:0] idx_in,
	input wire logic [DW-1:0] den_in,
	input wire logic [1:0] neg_in,
	input wire logic [DW-1:0] rem_x_in,
	input wire logic [DW-1:0] rem_y_in,
	input wire logic [QB-1:0] lq_x_in,
	input wire logic [QB-1:0] lq_y_in,
	input wire logic [DW-1:0] rwh_in,
	output logic v_out,
	input wire logic rdy_in,
	output logic [STEP_W-1:0] idx_out,
	output logic [DW-1:0] den_out,
	output logic [1:0] neg_out,
	output logic [DW-1:0] rem_x_out,
	output logic [DW-1:0] rem_y_out,
	output logic [QB-1:0] lq_x_out,
	output logic [QB-1:0] lq_y_out,
	output logic [DW-1:0] rwh_out
);
	logic v_q, en;
	logic [DW:0] tx, ty, dx, dy;
	logic gex, gey;
	logic [DW-1:0] rx_n, ry_n;

	assign en = !v_q || rdy_in;
	assign rdy_out = en;

	assign tx = {rem_x_in, lq_x_in[QB-1]};
	assign ty = {rem_y_in, lq_y_in[QB-1]};
	assign dx = tx - {1'b0, den_in};
	assign dy = ty - {1'b0, den_in};
	assign gex = tx >= {1'b0, den_in};
	assign gey = ty >= {1'b0, den_in};
	assign rx_n = gex ? dx[DW-1:0] : tx[DW-1:0];
	assign ry_n = gey ? dy[DW-1:0] : ty[DW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	// Dividend bits leave at the top of lq while quotient bits enter at the bottom.
	always_ff @(posedge clk) begin
		if (en && v_in) begin
			idx_out <= idx_in;
			den_out <= den_in;
			neg_out <= neg_in;
			rem_x_out <= rx_n;
			rem_y_out <= ry_n;
			lq_x_out <= {lq_x_in[QB-2:0], gex};
			lq_y_out <= {lq_y_in[QB-2:0], gey};
			rwh_out <= CAPTURE ? rx_n : rwh_in;
		end
	end

	assign v_out = v_q;

endmodule
`default_nettype wire

/* rtl/qbp_round.sv */
// Output stage: rounding to Q16.16, sign, saturation and the whole-number flag.
// Depends on qbp_pkg; takes the last divider cell and drives the result ports.
`default_nettype none
module qbp_round import qbp_pkg::*; #(
	parameter int DW = 22,
	parameter int QB = 33
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic v_in,
	output logic rdy_out,
	input wire logic [STEP_W-1:0] idx_in,
	input wire logic [DW-1:0] den_in,
	input wire logic [1:0] neg_in,
	input wire logic [QB-1:0] lq_x_in,
	input wire logic [QB-1:0] lq_y_in,
	input wire logic [DW-1:0] rwh_in,
	output logic out_valid,
	input wire logic out_ready,
	output logic [STEP_W-1:0] index_echo,
	output logic signed [OUT_W-1:0] curve_x,
	output logic signed [OUT_W-1:0] curve_y,
	output logic x_is_whole
);
	localparam int EW = (QB > OUT_W + 1) ? QB : OUT_W + 1;
	localparam logic [EW-1:0] POS_MAX = EW'(64'h7FFF_FFFF);
	localparam logic [EW-1:0] NEG_MAX = EW'(64'h8000_0000);

	logic en;
	logic [QB-1:0] lq [2];
	logic [QB:0] up [2];
	logic [EW-1:0] fx [2];
	logic [OUT_W-1:0] res [2];
	logic [DW+TOL_W-1:0] tol;

	assign en = !out_valid || out_ready;
	assign rdy_out = en;
	assign lq[0] = lq_x_in;
	assign lq[1] = lq_y_in;

	// The quotient carries one extra fraction bit, so adding one and dropping it
	// rounds half away from zero on the magnitude.
	always_comb begin
		for (int k = 0; k < 2; k++) begin
			up[k] = {1'b0, lq[k]} + (QB+1)'(1);
			fx[k] = EW'(up[k][QB:1]);
			if (neg_in[k]) begin
				res[k] = (fx[k] > NEG_MAX) ? (-NEG_MAX[OUT_W-1:0]) : (-fx[k][OUT_W-1:0]);
			end else begin
				res[k] = (fx[k] > POS_MAX) ? POS_MAX[OUT_W-1:0] : fx[k][OUT_W-1:0];
			end
		end
	end

	assign tol = rwh_in * WHOLE_TOL_INV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_in) begin
			index_echo <= idx_in;
			curve_x <= res[0];
			curve_y <= res[1];
			x_is_whole <= (tol <= {TOL_W'(0), den_in});
		end
	end

endmodule
`default_nettype wire

/* tb/qbp_checker.sv */
// Checker for the quadratic Bezier point evaluator: watches the config, input and output
// channels, predicts each curve point exactly and compares it field by field.
// Depends on qbp_pkg.
`default_nettype none
module qbp_checker import qbp_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [DATA_W-1:0] cfg_data,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic [STEP_W-1:0] step_index,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [STEP_W-1:0] index_echo,
	input wire logic signed [OUT_W-1:0] curve_x,
	input wire logic signed [OUT_W-1:0] curve_y,
	input wire logic x_is_whole,
	output int fail_count,
	output int points_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [STEP_W-1:0] idx;
		logic [OUT_W-1:0] x;
		logic [OUT_W-1:0] y;
		logic whole;
	} point_t;

	localparam longint MAX_N = 1024;

	longint ax, ay, bx, by, cx, cy;
	longint steps;
	point_t expected_points[$];

	assign points_pending = expected_points.size();

	// Exact division to Q16.16, rounded half away from zero, saturating.
	function automatic logic [OUT_W:0] q16_divide(longint num, longint den);
		longint mag, q, r, f, fx;
		logic neg, whole;
		neg = num < 0;
		mag = neg ? -num : num;
		q = mag / den;
		r = mag % den;
		f = ((r << 17) + den) / (2 * den);
		whole = (r * 100000 <= den);
		if (q > 64'h8000_0000)
			q = 64'h8000_0000;
		fx = (q << 16) + f;
		if (neg) begin
			if (fx > 64'h8000_0000)
				fx = 64'h8000_0000;
			fx = -fx;
		end else if (fx > 64'h7FFF_FFFF) begin
			fx = 64'h7FFF_FFFF;
		end
		return {whole, fx[31:0]};
	endfunction

	function automatic point_t bezier_point(logic [STEP_W-1:0] raw_idx);
		longint n, i, w0, w1, w2, den;
		logic [OUT_W:0] rx, ry;
		point_t p;
		n = steps;
		if (n < 1)
			n = 1;
		if (n > MAX_N)
			n = MAX_N;
		i = raw_idx;
		if (i > n)
			i = n;
		w0 = (n - i) * (n - i);
		w1 = 2 * (n - i) * i;
		w2 = i * i;
		den = n * n;
		rx = q16_divide(w0 * ax + w1 * bx + w2 * cx, den);
		ry = q16_divide(w0 * ay + w1 * by + w2 * cy, den);
		p.idx = i[STEP_W-1:0];
		p.x = rx[OUT_W-1:0];
		p.y = ry[OUT_W-1:0];
		p.whole = rx[OUT_W];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		point_t want;
		if (!arst_n) begin
			ax <= 0; ay <= 0; bx <= 0; by <= 0; cx <= 0; cy <= 0;
			steps <= 1;
			fail_count <= 0;
			expected_points.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_A_X: ax <= longint'($signed(cfg_data));
					REG_A_Y: ay <= longint'($signed(cfg_data));
					REG_B_X: bx <= longint'($signed(cfg_data));
					REG_B_Y: by <= longint'($signed(cfg_data));
					REG_C_X: cx <= longint'($signed(cfg_data));
					REG_C_Y: cy <= longint'($signed(cfg_data));
					REG_STEPS: steps <= longint'(cfg_data[STEP_W-1:0]);
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected output item idx=%0d", index_echo);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_points.pop_front();
					if (want.idx !== index_echo || want.x !== curve_x
							|| want.y !== curve_y || want.whole !== x_is_whole) begin
						if (fail_count < 10)
							$display("mismatch: exp idx=%0d x=%h y=%h w=%b got idx=%0d x=%h y=%h w=%b",
								want.idx, want.x, want.y, want.whole,
								index_echo, curve_x, curve_y, x_is_whole);
						fail_count <= fail_count + 1;
					end
				end
			end
			// Configuration only changes while idle, so the current registers apply.
			if (in_valid && in_ready)
				expected_points.push_back(bezier_point(step_index));
		end
	end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Top of the quadratic Bezier point testbench: clock, reset, configuration phases,
// index stimulus with random idling, and the verdict. Depends on qbp_pkg and qbp_checker.
`default_nettype none
module tb_top;
	import qbp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_ready;
	logic [STEP_W-1:0] step_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [STEP_W-1:0] index_echo;
	logic signed [OUT_W-1:0] curve_x, curve_y;
	logic x_is_whole;
	int fail_count, points_pending;
	bit calm_phase = 0;
	bit hold_output = 0;

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	quadratic_bezier_point DUT (.*);

	qbp_checker checker_inst (.*);

	task automatic write_reg(cfg_reg_t idx, logic [DATA_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_curve(logic [DATA_W-1:0] a_x, a_y, b_x, b_y, c_x, c_y,
			logic [DATA_W-1:0] n);
		write_reg(REG_A_X, a_x);
		write_reg(REG_A_Y, a_y);
		write_reg(REG_B_X, b_x);
		write_reg(REG_B_Y, b_y);
		write_reg(REG_C_X, c_x);
		write_reg(REG_C_Y, c_y);
		write_reg(REG_STEPS, n);
	endtask

	// Called at a falling edge. Valid stays high from one item to the next unless
	// the sender idles, so items can follow back to back; drain lowers it.
	task automatic send_index(logic [STEP_W-1:0] idx);
		while (!calm_phase && $urandom_range(99) < 6) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		step_index <= idx;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic drain;
		in_valid <= 0;
		while (points_pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
	endtask

	task automatic random_phase(int count, int max_n);
		int n;
		n = $urandom_range(max_n, 1);
		set_curve(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
			DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), DATA_W'(n));
		repeat (count) begin
			if ($urandom_range(9) == 0)
				send_index(STEP_W'($urandom_range(2047)));
			else
				send_index(STEP_W'($urandom_range(n + 2)));
		end
		drain();
	endtask

	// Receiver: random stalls, quiet when the calm phase runs, long hold on request.
	always @(negedge clk) begin
		if (hold_output)
			out_ready <= 0;
		else
			out_ready <= calm_phase || ($urandom_range(99) >= 6);
	end

	initial begin
		#20ms;
		$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// Reset registers: all points zero, N = 1.
		send_index(0);
		send_index(1);
		send_index(11'h7FF);
		drain();
		set_curve(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1024);
		send_index(0);
		send_index(1);
		send_index(512);
		send_index(1023);
		send_index(1024);
		send_index(1025);
		send_index(11'h7FF);
		drain();
		// Step count zero acts as one; a count above the maximum acts as the maximum.
		set_curve(16'h0003, 16'hFFFD, 16'h0005, 16'hFFF9, 16'hFFFF, 16'h0002, 0);
		send_index(0);
		send_index(1);
		send_index(2);
		drain();
		write_reg(REG_STEPS, 16'hFFFF);
		send_index(3);
		send_index(1024);
		send_index(1500);
		drain();
		write_reg(REG_STEPS, 16'd2047);
		send_index(700);
		drain();
		// Uneven fractions near whole numbers.
		set_curve(16'd1, 16'd1, 16'hFFFF, 16'd2, 16'd1, 16'hFFFE, 3);
		send_index(0);
		send_index(1);
		send_index(2);
		send_index(3);
		drain();

		// Long receiver hold while the sender keeps offering.
		set_curve(DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom),
			DATA_W'($urandom), DATA_W'($urandom), DATA_W'($urandom), 100);
		hold_output = 1;
		fork
			begin
				repeat (120) send_index(STEP_W'($urandom_range(101)));
			end
			begin
				repeat (300) @(posedge clk);
				hold_output = 0;
			end
		join
		drain();

		random_phase(100, 8);
		random_phase(100, 1024);
		calm_phase = 1;
		random_phase(80, 64);
		calm_phase = 0;
		random_phase(60, 3);
		random_phase(60, 1024);
		drain();

		if (fail_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire
